// ===== src/ffr_pkg.sv =====
// ffr_pkg: shared types, status codes and cosine table math for the
// fir frequency response block; no dependencies
`default_nettype none
package ffr_pkg;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_OOR = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  localparam logic CFG_NTAPS   = 1'b0;
  localparam logic CFG_NPOINTS = 1'b1;

  localparam int DIV_STEPS = 32;

  localparam longint CQ0 = 64'sd1073741824;
  localparam longint CQ1 = 64'sd1324675879;
  localparam longint CQ2 = 64'sd272375560;
  localparam longint CQ3 = 64'sd22401993;
  localparam longint CQ4 = 64'sd987048;
  localparam longint CQ5 = 64'sd27060;
  localparam longint CQ6 = 64'sd506;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } ffr_state_e;

  typedef struct packed {
    logic tap_wr;
    logic start;
    logic div_step;
    logic run_step;
    logic load_out;
  } ffr_cmd_t;

  typedef struct packed {
    logic oor;
    logic div_last;
    logic tap_last;
    logic pipe_busy;
  } ffr_stat_t;

  function automatic logic signed [63:0] mul_q30(input logic signed [63:0] r,
                                                 input logic [63:0] y);
    logic [63:0] u;
    u = (r < 0) ? 64'd0 : 64'(r);
    return signed'((u * y) >> 30);
  endfunction

  // x is i*2^30/depth; returns cos in q.15, 0..32768
  function automatic logic [16:0] cos_entry(input logic [63:0] x);
    logic [63:0] y;
    logic signed [63:0] r;
    y = (x * x) >> 30;
    r = CQ6;
    r = CQ5 - mul_q30(r, y);
    r = CQ4 - mul_q30(r, y);
    r = CQ3 - mul_q30(r, y);
    r = CQ2 - mul_q30(r, y);
    r = CQ1 - mul_q30(r, y);
    r = CQ0 - mul_q30(r, y);
    if (r < 0) r = 0;
    r = (r + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    return 17'(r);
  endfunction

endpackage
`default_nettype wire

// ===== src/ffr_stream_if.sv =====
// ffr_in_if and ffr_out_if: valid/ready channels for query and result items
// uses no package
`default_nettype none
interface ffr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [9:0]  tap_index;
  logic signed [15:0] tap_value;
  logic [15:0] point_index;
  modport source (output valid, mode, tap_index, tap_value, point_index, input ready);
  modport sink   (input valid, mode, tap_index, tap_value, point_index, output ready);
endinterface

interface ffr_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] resp_real;
  logic signed [31:0] resp_imag;
  logic [1:0]  status;
  modport source (output valid, resp_real, resp_imag, status, input ready);
  modport sink   (input valid, resp_real, resp_imag, status, output ready);
endinterface
`default_nettype wire

// ===== src/ffr_ctrl.sv =====
// ffr_ctrl: sequencer for tap writes and point queries
// depends on ffr_pkg
`default_nettype none
module ffr_ctrl
  import ffr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_mode_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  input  wire ffr_stat_t stat_i,
  output ffr_cmd_t       cmd_o
);

  ffr_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i) begin
            cmd_o.start = 1'b1;
            state_d = stat_i.oor ? ST_FIN : ST_DIV;
          end else begin
            cmd_o.tap_wr = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.run_step = 1'b1;
        if (stat_i.tap_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = ST_FIN;
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== src/ffr_datapath.sv =====
// ffr_datapath: tap memory, cosine table, phase divider, phase tracker,
// multiply-accumulate pipeline and output register; depends on ffr_pkg
`default_nettype none
module ffr_datapath
  import ffr_pkg::*;
#(
  parameter int MAX_TAPS        = 1024,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic [9:0]  tap_index_i,
  input  wire logic [15:0] tap_value_i,
  input  wire logic [15:0] point_index_i,
  input  wire ffr_cmd_t    cmd_i,
  output ffr_stat_t        stat_o,
  output logic signed [31:0] resp_real_o,
  output logic signed [31:0] resp_imag_o,
  output logic [1:0]       status_o
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int KW    = $clog2(MAX_TAPS + 1);
  localparam int RW    = $clog2(COS_TABLE_DEPTH + 1);
  localparam int QW    = $clog2(8 * COS_TABLE_DEPTH + 2);
  localparam int ACC_W = 34 + $clog2(MAX_TAPS + 1);
  localparam int CW    = $clog2(DIV_STEPS);
  localparam logic [31:0] FOURD = 32'(4 * COS_TABLE_DEPTH);
  localparam logic [QW-1:0] QD1 = QW'(COS_TABLE_DEPTH);
  localparam logic [QW-1:0] QD2 = QW'(2 * COS_TABLE_DEPTH);
  localparam logic [QW-1:0] QD3 = QW'(3 * COS_TABLE_DEPTH);
  localparam logic [QW-1:0] QD4 = QW'(4 * COS_TABLE_DEPTH);
  localparam logic [RW-1:0] RD  = RW'(COS_TABLE_DEPTH);

  // configuration
  logic [10:0] ntaps_q;
  logic [16:0] npoints_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ntaps_q   <= 11'd1;
      npoints_q <= 17'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NTAPS:   ntaps_q   <= cfg_data_i[10:0];
        CFG_NPOINTS: npoints_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [16:0] pc_eff;
  logic [KW-1:0] taps_last;
  logic [16:0] p_ext;
  always_comb begin
    if (npoints_q < 17'd2) pc_eff = 17'd2;
    else if (npoints_q > 17'd65536) pc_eff = 17'd65536;
    else pc_eff = npoints_q;
    if (ntaps_q == 11'd0) taps_last = '0;
    else if (32'(ntaps_q) > MAX_TAPS) taps_last = KW'(MAX_TAPS - 1);
    else taps_last = KW'(ntaps_q - 11'd1);
    p_ext = {1'b0, point_index_i};
  end

  // tap memory
  logic [15:0] tap_mem [MAX_TAPS];
  logic [15:0] tap_rd_q;
  logic [KW-1:0] k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_wr && (32'(tap_index_i) < MAX_TAPS))
      tap_mem[AW'(tap_index_i)] <= tap_value_i;
    tap_rd_q <= tap_mem[AW'(k_q)];
  end

  // cosine table, quarter wave, built at elaboration
  logic [16:0] rom_w [COS_TABLE_DEPTH + 1];
  for (genvar i = 0; i <= COS_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] X = (64'(i) << 30) / COS_TABLE_DEPTH;
    assign rom_w[i] = cos_entry(X);
  end

  // query registers
  logic [15:0] p_q;
  logic [16:0] n_q;
  logic        edge_q, alt_q, oor_q;
  logic [KW-1:0] last_q;

  // restoring divider for p*4D / n
  logic [31:0] quo_q;
  logic [16:0] rem_q;
  logic [CW-1:0] dcnt_q;
  logic [17:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, quo_q[31]};
  assign rem_ge = rem_sh >= {1'b0, n_q};

  // phase tracker: pos = floor((ph*4D + n/2)/n) kept as quotient and remainder
  logic [QW-1:0] q_q;
  logic [16:0]   r_q, ph_q;
  logic [QW-1:0] pos;
  logic [1:0]    quad;
  logic [QW-1:0] off;
  logic [17:0]   ph_sum, r_sum;
  logic          ph_wrap, r_carry;

  always_comb begin
    pos = (q_q == QD4) ? '0 : q_q;
    if (pos >= QD3) begin
      quad = 2'd3; off = pos - QD3;
    end else if (pos >= QD2) begin
      quad = 2'd2; off = pos - QD2;
    end else if (pos >= QD1) begin
      quad = 2'd1; off = pos - QD1;
    end else begin
      quad = 2'd0; off = pos;
    end
    ph_sum  = {1'b0, ph_q} + {2'b0, p_q};
    ph_wrap = ph_sum >= {1'b0, n_q};
    r_sum   = {1'b0, r_q} + {1'b0, rem_q};
    r_carry = r_sum >= {1'b0, n_q};
  end

  // pipeline stage 1
  logic          v1_q, v2_q;
  logic [16:0]   rom_a_q, rom_b_q;
  logic [1:0]    quad_q;
  logic          odd_q;
  // stage 2
  logic signed [33:0] prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;

  always_ff @(posedge clk_i) begin
    rom_a_q <= rom_w[RW'(off)];
    rom_b_q <= rom_w[RD - RW'(off)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      k_q    <= '0;
      dcnt_q <= '0;
    end else begin
      v1_q <= cmd_i.run_step;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        k_q    <= '0;
        dcnt_q <= '0;
      end else begin
        if (cmd_i.run_step) k_q <= k_q + KW'(1);
        if (cmd_i.div_step) dcnt_q <= dcnt_q + CW'(1);
      end
    end
  end

  logic signed [17:0] c_sel, sn_sel;
  logic signed [17:0] a_s, b_s;
  always_comb begin
    a_s = signed'({1'b0, rom_a_q});
    b_s = signed'({1'b0, rom_b_q});
    if (edge_q) begin
      c_sel  = (alt_q && odd_q) ? -18'sd32768 : 18'sd32768;
      sn_sel = '0;
    end else begin
      case (quad_q)
        2'd0:    begin c_sel = a_s;  sn_sel = -b_s; end
        2'd1:    begin c_sel = -b_s; sn_sel = -a_s; end
        2'd2:    begin c_sel = -a_s; sn_sel = b_s;  end
        default: begin c_sel = b_s;  sn_sel = a_s;  end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      p_q    <= point_index_i;
      n_q    <= 17'((pc_eff - 17'd1) << 1);
      edge_q <= (point_index_i == 16'd0) || (p_ext == pc_eff - 17'd1);
      alt_q  <= point_index_i != 16'd0;
      oor_q  <= p_ext >= pc_eff;
      last_q <= taps_last;
      quo_q  <= 32'(point_index_i) * FOURD;
      rem_q  <= '0;
      q_q    <= '0;
      r_q    <= pc_eff - 17'd1;
      ph_q   <= '0;
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      if (cmd_i.div_step) begin
        quo_q <= {quo_q[30:0], rem_ge};
        rem_q <= rem_ge ? 17'(rem_sh - {1'b0, n_q}) : rem_sh[16:0];
      end
      if (cmd_i.run_step) begin
        ph_q <= ph_wrap ? 17'(ph_sum - {1'b0, n_q}) : ph_sum[16:0];
        r_q  <= r_carry ? 17'(r_sum - {1'b0, n_q}) : r_sum[16:0];
        q_q  <= q_q + QW'(quo_q) + QW'(r_carry) - (ph_wrap ? QD4 : '0);
      end
      if (v2_q) begin
        acc_re_q <= acc_re_q + {{(ACC_W-34){prod_re_q[33]}}, prod_re_q};
        acc_im_q <= acc_im_q + {{(ACC_W-34){prod_im_q[33]}}, prod_im_q};
      end
    end
    quad_q    <= quad;
    odd_q     <= k_q[0];
    prod_re_q <= signed'(tap_rd_q) * c_sel;
    prod_im_q <= signed'(tap_rd_q) * sn_sel;
  end

  // rounding to q16.15 and saturation
  logic signed [63:0] re64, im64;
  logic signed [31:0] re_sat, im_sat;
  logic sat_re, sat_im;
  always_comb begin
    re64 = (signed'({{(64-ACC_W){acc_re_q[ACC_W-1]}}, acc_re_q}) + 64'sd16384) >>> 15;
    im64 = (signed'({{(64-ACC_W){acc_im_q[ACC_W-1]}}, acc_im_q}) + 64'sd16384) >>> 15;
    sat_re = 1'b1;
    sat_im = 1'b1;
    if (re64 > 64'sd2147483647) re_sat = 32'sh7fffffff;
    else if (re64 < -64'sd2147483648) re_sat = 32'sh80000000;
    else begin re_sat = 32'(re64); sat_re = 1'b0; end
    if (im64 > 64'sd2147483647) im_sat = 32'sh7fffffff;
    else if (im64 < -64'sd2147483648) im_sat = 32'sh80000000;
    else begin im_sat = 32'(im64); sat_im = 1'b0; end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (oor_q) begin
        resp_real_o <= '0;
        resp_imag_o <= '0;
        status_o    <= STATUS_OOR;
      end else begin
        resp_real_o <= re_sat;
        resp_imag_o <= im_sat;
        status_o    <= (sat_re || sat_im) ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign stat_o.oor       = p_ext >= pc_eff;
  assign stat_o.div_last  = dcnt_q == CW'(DIV_STEPS - 1);
  assign stat_o.tap_last  = k_q == last_q;
  assign stat_o.pipe_busy = v1_q || v2_q;

endmodule
`default_nettype wire

// ===== src/fir_frequency_response.sv =====
// fir_frequency_response: top level, joins the sequencer and the datapath
// depends on ffr_pkg, ffr_in_if, ffr_out_if, ffr_ctrl, ffr_datapath
`default_nettype none
// A tap write item is written to the tap memory as it is accepted. A query
// item runs a restoring divider that splits p*4*COS_TABLE_DEPTH by the turn
// length, then the configured taps in the single multiply-accumulate
// pipeline, then a drain and the output load. The next item is taken while
// a result still waits in the output register. Points at or past the configured
// grid size skip the divider and the pipeline and return status 1. Taps must
// be written before a query reads them.
module fir_frequency_response
  import ffr_pkg::*;
#(
  parameter int MAX_TAPS        = 1024,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  ffr_in_if.sink           in_if,
  ffr_out_if.source        out_if
);

  ffr_cmd_t  cmd;
  ffr_stat_t stat;

  ffr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_mode_i   (in_if.mode),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffr_datapath #(
    .MAX_TAPS        (MAX_TAPS),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .tap_index_i   (in_if.tap_index),
    .tap_value_i   (in_if.tap_value),
    .point_index_i (in_if.point_index),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .resp_real_o   (out_if.resp_real),
    .resp_imag_o   (out_if.resp_imag),
    .status_o      (out_if.status)
  );

endmodule
`default_nettype wire

// ===== src/ffr_checker.sv =====
// ffr_checker: port-level assertions for fir_frequency_response, with bind
// depends on ffr_pkg
`default_nettype none
module ffr_checker
  import ffr_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] resp_real,
  input wire logic [31:0] resp_imag,
  input wire logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(resp_real) && $stable(resp_imag))
    else $error("stalled result item changed");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STATUS_OOR |-> resp_real == '0 && resp_imag == '0)
    else $error("out of range item carries data");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STATUS_SAT |->
      resp_real == 32'h7fffffff || resp_real == 32'h80000000 ||
      resp_imag == 32'h7fffffff || resp_imag == 32'h80000000)
    else $error("saturated item with no part at a bound");

  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result item appeared right after an accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status == STATUS_OK || status == STATUS_OOR || status == STATUS_SAT)
    else $error("undefined status code");

endmodule

bind fir_frequency_response ffr_checker u_ffr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .resp_real (out_if.resp_real),
  .resp_imag (out_if.resp_imag),
  .status    (out_if.status)
);
`default_nettype wire
